### hw/rtl/csort_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csort_pkg
// Shared types and constants for the counting sort engine.
// ----------------------------------------------------------------------------
package csort_pkg;

  localparam int IN_KEY_W  = 8;  // width of the key field on the input side
  localparam int OUT_KEY_W = 8;  // width of the sorted key on the result side
  localparam int HIST_W    = 7;  // width of one histogram count

  // per-transaction classification from the front end
  typedef struct packed {
    logic counted;  // key fits in the current set
    logic last;     // closes the set and starts the sorted run
    logic dropped;  // some key of this set was ignored (valid with last)
  } csort_flags_t;

  // one sorted result
  typedef struct packed {
    logic [OUT_KEY_W-1:0] key;
    logic                 last;
    logic                 dropped;
  } csort_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAIN,
    ST_READ,
    ST_LOAD,
    ST_EMIT
  } csort_state_t;

endpackage : csort_pkg
`default_nettype wire

### hw/rtl/csort_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csort_fifo
// Small synchronous queue with full and empty flags.
// ----------------------------------------------------------------------------
module csort_fifo #(
  parameter int WIDTH      = 8,
  parameter int DEPTH_LOG2 = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [DEPTH_LOG2:0] wr_ptr_r, wr_ptr_nxt;
  logic [DEPTH_LOG2:0] rd_ptr_r, rd_ptr_nxt;
  logic                do_wr;
  logic                do_rd;

  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[DEPTH_LOG2] != rd_ptr_r[DEPTH_LOG2]) &&
                 (wr_ptr_r[DEPTH_LOG2-1:0] == rd_ptr_r[DEPTH_LOG2-1:0]);

  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rd_ptr_r[DEPTH_LOG2-1:0]];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r[DEPTH_LOG2-1:0]] <= wr_data;
    end
  end

endmodule : csort_fifo
`default_nettype wire

### hw/rtl/csort_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csort_front
// Accepts keys, tracks set capacity, largest key and drops, and classifies
// each transaction into a command for the back end.
// ----------------------------------------------------------------------------
module csort_front #(
  parameter int KEY_BITS  = 8,
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [csort_pkg::IN_KEY_W-1:0] in_key,
  input  wire logic                           in_last_key,
  input  wire logic                           clearing,
  input  wire logic                           cmd_full,
  output logic                                cmd_push,
  output logic      [KEY_BITS-1:0]            cmd_key,
  output logic      [KEY_BITS-1:0]            cmd_largest,
  output csort_pkg::csort_flags_t             cmd_flags
);

  import csort_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CNT_W-1:0]    item_cnt_r, item_cnt_nxt;
  logic [KEY_BITS-1:0] largest_r, largest_nxt;
  logic                ovf_r, ovf_nxt;
  logic [KEY_BITS-1:0] key_k;
  logic [KEY_BITS-1:0] largest_upd;
  logic                counted;
  logic                accept;

  assign full    = cmd_full | clearing;
  assign accept  = push & ~full;
  assign key_k   = KEY_BITS'(in_key);
  assign counted = (item_cnt_r < CNT_W'(MAX_ITEMS));
  assign largest_upd = (counted && (key_k > largest_r)) ? key_k : largest_r;

  assign cmd_push          = accept;
  assign cmd_key           = key_k;
  assign cmd_largest       = largest_upd;
  assign cmd_flags.counted = counted;
  assign cmd_flags.last    = in_last_key;
  assign cmd_flags.dropped = ovf_r | ~counted;

  always_comb begin
    item_cnt_nxt = item_cnt_r;
    largest_nxt  = largest_r;
    ovf_nxt      = ovf_r;
    if (accept) begin
      if (in_last_key) begin
        // set closes, next transaction starts a fresh one
        item_cnt_nxt = '0;
        largest_nxt  = '0;
        ovf_nxt      = 1'b0;
      end else begin
        item_cnt_nxt = item_cnt_r + CNT_W'(counted);
        largest_nxt  = largest_upd;
        ovf_nxt      = ovf_r | ~counted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_cnt_r <= '0;
      largest_r  <= '0;
      ovf_r      <= 1'b0;
    end else begin
      item_cnt_r <= item_cnt_nxt;
      largest_r  <= largest_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

endmodule : csort_front
`default_nettype wire

### hw/rtl/csort_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csort_back
// Holds the histogram memory, applies counted keys with a read-modify-write
// pipeline and walks the histogram to emit the sorted run, zeroing it as it
// goes. Clears the whole memory once after reset.
// ----------------------------------------------------------------------------
module csort_back #(
  parameter int KEY_BITS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cmd_empty,
  input  wire logic [KEY_BITS-1:0]     cmd_key,
  input  wire logic [KEY_BITS-1:0]     cmd_largest,
  input  wire csort_pkg::csort_flags_t cmd_flags,
  output logic                         cmd_pop,
  input  wire logic                    res_full,
  output logic                         res_push,
  output csort_pkg::csort_res_t        res_data,
  output logic                         clearing
);

  import csort_pkg::*;

  localparam int NUM_KEYS = 1 << KEY_BITS;

  logic [HIST_W-1:0]   hist_mem [NUM_KEYS];
  logic [HIST_W-1:0]   rd_r;

  csort_state_t        state_r, state_nxt;
  logic [KEY_BITS-1:0] v_r, v_nxt;
  logic [HIST_W-1:0]   cnt_r, cnt_nxt;
  logic [KEY_BITS-1:0] largest_r, largest_nxt;
  logic                drop_r, drop_nxt;

  // update pipeline: stage b holds the key whose count is on rd_r
  logic                b_valid_r, b_valid_nxt;
  logic [KEY_BITS-1:0] b_key_r;
  logic                w_valid_r;
  logic [KEY_BITS-1:0] w_key_r;
  logic [HIST_W-1:0]   w_data_r;

  logic                we;
  logic [KEY_BITS-1:0] wa;
  logic [HIST_W-1:0]   wd;
  logic [KEY_BITS-1:0] ra;
  logic [HIST_W-1:0]   upd_data;
  logic                run_end;

  // forward the previous write when the same key comes back to back
  assign upd_data = ((w_valid_r && (w_key_r == b_key_r)) ? w_data_r : rd_r) + HIST_W'(1);
  assign run_end  = (v_r == largest_r);
  assign clearing = (state_r == ST_CLEAR);

  always_comb begin
    state_nxt   = state_r;
    v_nxt       = v_r;
    cnt_nxt     = cnt_r;
    largest_nxt = largest_r;
    drop_nxt    = drop_r;
    b_valid_nxt = 1'b0;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res_data.key     = OUT_KEY_W'(v_r);
    res_data.last    = run_end && (cnt_r == HIST_W'(1));
    res_data.dropped = run_end && (cnt_r == HIST_W'(1)) && drop_r;
    we = b_valid_r;
    wa = b_key_r;
    wd = upd_data;
    ra = cmd_key;

    case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        wa = v_r;
        wd = '0;
        v_nxt = v_r + 1'b1;
        if (v_r == KEY_BITS'(NUM_KEYS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop     = 1'b1;
          b_valid_nxt = cmd_flags.counted;
          if (cmd_flags.last) begin
            largest_nxt = cmd_largest;
            drop_nxt    = cmd_flags.dropped;
            v_nxt       = '0;
            state_nxt   = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // last count update lands this cycle
        state_nxt = ST_READ;
      end
      ST_READ: begin
        ra        = v_r;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cnt_nxt = rd_r;
        we      = 1'b1;
        wa      = v_r;
        wd      = '0;
        if (rd_r != '0) begin
          state_nxt = ST_EMIT;
        end else if (run_end) begin
          state_nxt = ST_IDLE;
        end else begin
          v_nxt     = v_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_EMIT: begin
        if (!res_full) begin
          res_push = 1'b1;
          cnt_nxt  = cnt_r - HIST_W'(1);
          if (cnt_r == HIST_W'(1)) begin
            if (run_end) begin
              state_nxt = ST_IDLE;
            end else begin
              v_nxt     = v_r + 1'b1;
              state_nxt = ST_READ;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      b_valid_r <= 1'b0;
      w_valid_r <= 1'b0;
    end else begin
      v_r       <= v_nxt;
      b_valid_r <= b_valid_nxt;
      w_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    largest_r <= largest_nxt;
    drop_r    <= drop_nxt;
    b_key_r   <= cmd_key;
    w_key_r   <= b_key_r;
    w_data_r  <= upd_data;
  end

  // histogram memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      hist_mem[wa] <= wd;
    end
    rd_r <= hist_mem[ra];
  end

endmodule : csort_back
`default_nettype wire

### hw/rtl/counting_sort_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counting_sort_engine
// Counting sort over sets of unsigned keys, emitting each set in ascending
// order once its last key arrives.
// ----------------------------------------------------------------------------
// Keys are taken one per cycle while full is low and counted into a
// 2^KEY_BITS entry histogram memory; at most MAX_ITEMS keys per set are held,
// later ones are dropped and flagged on the final result. The transaction
// marked last closes the set and starts the sorted run: the back end walks the
// histogram from key 0 up to the largest held key, with a memory read and a
// load for each key value and then its results one by one, zeroing each entry
// as it passes. A small command queue sits between the front end and the
// histogram, so keys of the next set are accepted while a run is still being
// emitted, until that queue fills. After reset the block clears the histogram
// memory, holding full high meanwhile.
// ----------------------------------------------------------------------------
module counting_sort_engine #(
  parameter int KEY_BITS  = 8,
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [csort_pkg::IN_KEY_W-1:0]  in_key,
  input  wire logic                            in_last_key,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic      [csort_pkg::OUT_KEY_W-1:0] out_sorted_key,
  output logic                                 out_last_out,
  output logic                                 out_dropped
);

  import csort_pkg::*;

  localparam int FLAGS_W = $bits(csort_flags_t);
  localparam int CMD_W   = 2 * KEY_BITS + FLAGS_W;
  localparam int RES_W   = $bits(csort_res_t);

  logic                clearing;
  logic                cmd_full;
  logic                cmd_empty;
  logic                cmd_push;
  logic                cmd_pop;
  logic [KEY_BITS-1:0] f_key;
  logic [KEY_BITS-1:0] f_largest;
  csort_flags_t        f_flags;
  logic [CMD_W-1:0]    cmd_wr;
  logic [CMD_W-1:0]    cmd_rd;
  csort_flags_t        b_flags;
  logic                res_full;
  logic                res_push;
  csort_res_t          res_wr;
  logic [RES_W-1:0]    res_rd;
  csort_res_t          res_head;

  csort_front #(
    .KEY_BITS  (KEY_BITS),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_key      (in_key),
    .in_last_key (in_last_key),
    .clearing    (clearing),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd_key     (f_key),
    .cmd_largest (f_largest),
    .cmd_flags   (f_flags)
  );

  assign cmd_wr = {f_key, f_largest, f_flags};

  csort_fifo #(
    .WIDTH      (CMD_W),
    .DEPTH_LOG2 (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_wr),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  assign b_flags = csort_flags_t'(cmd_rd[FLAGS_W-1:0]);

  csort_back #(
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_empty   (cmd_empty),
    .cmd_key     (cmd_rd[CMD_W-1 -: KEY_BITS]),
    .cmd_largest (cmd_rd[FLAGS_W +: KEY_BITS]),
    .cmd_flags   (b_flags),
    .cmd_pop     (cmd_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_data    (res_wr),
    .clearing    (clearing)
  );

  // result queue decouples the histogram walk from the consumer
  csort_fifo #(
    .WIDTH      (RES_W),
    .DEPTH_LOG2 (1)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign res_head       = csort_res_t'(res_rd);
  assign out_sorted_key = res_head.key;
  assign out_last_out   = res_head.last;
  assign out_dropped    = res_head.dropped;

endmodule : counting_sort_engine
`default_nettype wire
